>>> rtl/core/row_led_status_sequencer_unit_defines.svh
// Assertion macros for the row LED status sequencer.
// Taken in by the modules that carry concurrent assertions; no other dependencies.
`ifndef ROW_LED_STATUS_SEQUENCER_UNIT_DEFINES_SVH
`define ROW_LED_STATUS_SEQUENCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlss: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RLSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlss: next-cycle check failed");

`endif

>>> rtl/core/rlss_pkg.sv
// Shared types and constants of the row LED status sequencer.
// No dependencies; imported by the step logic and the top level.
package rlss_pkg;

    localparam int ROWS       = 4;
    localparam int CNT_W      = 3;
    localparam int TIMER_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_POST_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLINK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_BLINK    = 2'd2;

    typedef enum logic [2:0] {
        MODE_POST   = 3'd0,
        MODE_WAIT   = 3'd1,
        MODE_NORMAL = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_ERROR  = 3'd4
    } t_mode;

    typedef struct packed {
        logic [TIMER_W-1:0] timer_value;
        logic               system_error;
        logic               flow_detected;
        logic               blockage_flag;
        logic [ROWS-1:0]    blocked_rows;
        logic [ROWS-1:0]    no_magnet_rows;
    } t_item;

    typedef struct packed {
        logic [ROWS-1:0] led_bits;
        logic            clear_blockage;
        logic [2:0]      mode;
    } t_result;

    typedef struct packed {
        logic [TIMER_W-1:0] post_duration_ticks;
        logic [CNT_W-1:0]   slow_blink_steps;
        logic [TIMER_W-1:0] fast_blink_ticks;
    } t_cfg;

    typedef struct packed {
        t_mode                       mode;
        logic [TIMER_W-1:0]          blink_start;
        logic [ROWS-1:0][CNT_W-1:0]  row_blink_count;
        logic [ROWS-1:0]             led_latch;
    } t_state;

endpackage

>>> rtl/core/rlss_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// The payload type is set by the instantiating scope; no other dependencies.
interface rlss_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/rlss_step.sv
// Combinational step of the row LED status sequencer: next state and result.
// Depends on rlss_pkg.
module rlss_step
    import rlss_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_mode                      n_mode;
    logic [ROWS-1:0]            n_led;
    logic [ROWS-1:0][CNT_W-1:0] n_cnt;
    logic [TIMER_W-1:0]         n_start;
    logic                       n_clr;

    logic [ROWS-1:0][CNT_W-1:0] w_cnt_next;
    logic [ROWS-1:0]            w_toggle;
    logic [TIMER_W-1:0]         w_due;

    // Slow blink counters advance with wrap and toggle once past the limit.
    always_comb begin
        logic [CNT_W-1:0] v_inc;
        for (int r = 0; r < ROWS; r++) begin
            v_inc         = i_state.row_blink_count[r] + CNT_W'(1);
            w_toggle[r]   = v_inc > i_cfg.slow_blink_steps;
            w_cnt_next[r] = w_toggle[r] ? '0 : v_inc;
        end
    end

    assign w_due = i_state.blink_start + i_cfg.fast_blink_ticks;

    // Next mode.
    always_comb begin
        n_mode = i_state.mode;
        unique case (i_state.mode)
            MODE_POST: begin
                if (i_item.timer_value > i_cfg.post_duration_ticks) n_mode = MODE_WAIT;
            end
            MODE_WAIT: begin
                if (i_item.system_error)       n_mode = MODE_ERROR;
                else if (i_item.flow_detected) n_mode = MODE_NORMAL;
            end
            MODE_NORMAL: begin
                if (i_item.system_error)       n_mode = MODE_ERROR;
                else if (i_item.blockage_flag) n_mode = MODE_BLOCK;
            end
            MODE_BLOCK: begin
                if (i_item.system_error)          n_mode = MODE_ERROR;
                else if (i_item.blocked_rows == '0) n_mode = MODE_NORMAL;
            end
            MODE_ERROR: begin
                if (!i_item.system_error) n_mode = MODE_NORMAL;
            end
            default: ;
        endcase
    end

    // LEDs, counters and blink timing.
    always_comb begin
        n_led   = i_state.led_latch;
        n_cnt   = i_state.row_blink_count;
        n_start = i_state.blink_start;
        n_clr   = 1'b0;
        unique case (i_state.mode)
            MODE_POST: begin
                n_led = '1;
            end
            MODE_WAIT: begin
                if (i_item.system_error) begin
                    n_led   = '0;
                    n_start = i_item.timer_value;
                end else if (i_item.flow_detected) begin
                    n_led = '1;
                    n_cnt = '0;
                end else begin
                    // All rows blink together on the row 0 counter.
                    n_cnt[0] = w_cnt_next[0];
                    if (w_toggle[0]) n_led = ~i_state.led_latch;
                end
            end
            MODE_NORMAL: begin
                if (i_item.system_error) begin
                    n_led   = '0;
                    n_start = i_item.timer_value;
                end else begin
                    n_led = ~i_item.no_magnet_rows;
                    if (i_item.blockage_flag) n_start = i_item.timer_value;
                end
            end
            MODE_BLOCK: begin
                if (i_item.system_error) begin
                    n_led   = '0;
                    n_start = i_item.timer_value;
                end else begin
                    for (int r = 0; r < ROWS; r++) begin
                        if (i_item.blocked_rows[r]) begin
                            n_cnt[r] = w_cnt_next[r];
                            if (w_toggle[r]) n_led[r] = ~i_state.led_latch[r];
                        end else if (i_item.no_magnet_rows[r]) begin
                            n_led[r] = 1'b0;
                        end else begin
                            n_led[r] = 1'b1;
                            n_cnt[r] = '0;
                        end
                    end
                    if (i_item.blocked_rows == '0) begin
                        n_led = ~i_item.no_magnet_rows;
                        n_clr = 1'b1;
                    end
                end
            end
            MODE_ERROR: begin
                if (i_item.system_error && (i_item.timer_value >= w_due)) begin
                    n_led   = ~i_state.led_latch;
                    n_start = i_item.timer_value;
                end
            end
            default: ;
        endcase
    end

    assign o_state.mode            = n_mode;
    assign o_state.blink_start     = n_start;
    assign o_state.row_blink_count = n_cnt;
    assign o_state.led_latch       = n_led;

    assign o_result.led_bits       = n_led;
    assign o_result.clear_blockage = n_clr;
    assign o_result.mode           = n_mode;

endmodule

>>> rtl/core/row_led_status_sequencer_unit.sv
// Each accepted beat's result is registered in the output entry, or in the skid entry while the output is held.
// Throughput: one beat per cycle; a two-entry output buffer keeps the input open
// while one finished result waits, so the input stalls only when both entries are full.
// Reset (synchronous, active low): self test mode, LEDs off, blink counters and
// blink start cleared, registers at 8 / 4 / 1, output buffer empty.
`include "row_led_status_sequencer_unit_defines.svh"

module row_led_status_sequencer_unit
    import rlss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rlss_stream_if.sink           i_item,
    rlss_stream_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;

    t_result r_out;
    logic    r_out_v;
    t_result r_skid;
    logic    r_skid_v;

    logic    w_in_fire;
    logic    w_out_fire;
    t_item   w_item;

    assign w_item     = i_item.payload;
    assign w_in_fire  = i_item.valid && i_item.ready;
    assign w_out_fire = r_out_v && o_result.ready;

    assign i_item.ready     = !r_skid_v;
    assign o_result.valid   = r_out_v;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.post_duration_ticks <= 8'd8;
            r_cfg.slow_blink_steps    <= 3'd4;
            r_cfg.fast_blink_ticks    <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POST_DURATION: r_cfg.post_duration_ticks <= i_cfg_data;
                CFG_SLOW_BLINK:    r_cfg.slow_blink_steps    <= i_cfg_data[CNT_W-1:0];
                CFG_FAST_BLINK:    r_cfg.fast_blink_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rlss_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (w_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= MODE_POST;
            r_state.blink_start     <= '0;
            r_state.row_blink_count <= '0;
            r_state.led_latch       <= '0;
        end else if (w_in_fire) begin
            r_state <= n_state;
        end
    end

    // The skid entry fills only while the output entry is held by the sink.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_out_fire) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_out_fire) begin
            if (r_skid_v)       r_out <= r_skid;
            else if (w_in_fire) r_out <= n_result;
        end else if (w_in_fire) begin
            r_skid <= n_result;
        end
    end

    `RLSS_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `RLSS_ASSERT_NEXT(a_state_holds_idle, i_clk, i_rst_n, !w_in_fire, $stable(r_state))
    `RLSS_ASSERT_SAME(a_clear_in_normal, i_clk, i_rst_n,
        r_out_v && r_out.clear_blockage, r_out.mode == MODE_NORMAL)
    `RLSS_ASSERT_NEXT(a_error_exit, i_clk, i_rst_n,
        w_in_fire && (r_state.mode == MODE_ERROR) && !w_item.system_error,
        r_state.mode == MODE_NORMAL)

endmodule
